>>> hdl/xoshiro_range_random_generator_unit_defines.svh
// Assertion macros shared by the generator RTL.
// Self-contained; included by the modules that carry assertions.
`ifndef XOSHIRO_RANGE_RANDOM_GENERATOR_UNIT_DEFINES_SVH
`define XOSHIRO_RANGE_RANDOM_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define XRRG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define XRRG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/xrrg_pkg.sv
// Shared types and constants for the xoshiro256** range generator.
// No dependencies; imported by every module of the block.
package xrrg_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;
    localparam int CNT_W  = $clog2(WORD_W + 1);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [HALF_W-1:0] half_t;
    typedef logic [1:0]        req_t;

    localparam req_t REQ_RESEED  = 2'd0;
    localparam req_t REQ_RAW     = 2'd1;
    localparam req_t REQ_UNIFORM = 2'd2;
    localparam req_t REQ_CHANCE  = 2'd3;

    localparam word_t GOLDEN_STEP   = 64'h9E37_79B9_7F4A_7C15;
    localparam word_t MIX_MUL_A     = 64'hBF58_476D_1CE4_E5B9;
    localparam word_t MIX_MUL_B     = 64'h94D0_49BB_1331_11EB;
    localparam word_t ZERO_SEED_SUB = 64'hA5A5_A5A5_DEAD_BEEF;

endpackage

>>> hdl/xrrg_mul.sv
// Multi-cycle 64 x 64 multiplier returning the low 64 bits of the product.
// Built around one 32 x 32 multiplier; depends on xrrg_pkg.
module xrrg_mul
    import xrrg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t op_a,
    input  word_t op_b,
    output logic  done,
    output word_t product
);

    localparam logic [2:0] PH_LL  = 3'd0;
    localparam logic [2:0] PH_LH  = 3'd1;
    localparam logic [2:0] PH_HL  = 3'd2;
    localparam logic [2:0] PH_SUM = 3'd3;
    localparam logic [2:0] PH_OUT = 3'd4;

    word_t       a_reg;
    word_t       b_reg;
    word_t       part_reg;
    word_t       low_reg;
    half_t       cross_reg;
    word_t       product_reg;
    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    half_t       mul_x;
    half_t       mul_y;
    word_t       part_calc;

    // Operand selection for the shared 32 x 32 multiplier.
    always_comb
    begin
        unique case (phase_reg)
            PH_LH:
            begin
                mul_x = a_reg[HALF_W-1:0];
                mul_y = b_reg[WORD_W-1:HALF_W];
            end
            PH_HL:
            begin
                mul_x = a_reg[WORD_W-1:HALF_W];
                mul_y = b_reg[HALF_W-1:0];
            end
            default:
            begin
                mul_x = a_reg[HALF_W-1:0];
                mul_y = b_reg[HALF_W-1:0];
            end
        endcase
    end

    assign part_calc = mul_x * mul_y;

    always_comb
    begin
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            phase_next = PH_LL;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (phase_reg == PH_OUT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                phase_next = phase_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LL;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        else if (busy_reg)
        begin
            unique case (phase_reg)
                PH_LL:
                begin
                    part_reg <= part_calc;
                end
                PH_LH:
                begin
                    low_reg  <= part_reg;
                    part_reg <= part_calc;
                end
                PH_HL:
                begin
                    cross_reg <= part_reg[HALF_W-1:0];
                    part_reg  <= part_calc;
                end
                PH_SUM:
                begin
                    cross_reg <= cross_reg + part_reg[HALF_W-1:0];
                end
                default:
                begin
                    product_reg <= low_reg + {cross_reg, {HALF_W{1'b0}}};
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign product = product_reg;

endmodule

>>> hdl/xrrg_rem.sv
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Gives dividend modulo a nonzero divisor; depends on xrrg_pkg.
module xrrg_rem
    import xrrg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t dividend,
    input  word_t divisor,
    output logic  done,
    output word_t remainder
);

    word_t            dvd_reg;
    word_t            dsr_reg;
    word_t            rem_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [WORD_W:0]  trial;
    logic [WORD_W:0]  diff;
    word_t            rem_step;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    assign trial    = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign rem_step = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];

    always_comb
    begin
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            count_next = CNT_W'(WORD_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/xoshiro_range_random_generator_unit.sv
// Top level of the xoshiro256** range generator: sequencer, state words, output register.
// Depends on xrrg_pkg, xrrg_mul, xrrg_rem and the assertion macro header.
//
// This block is a xoshiro256** generator with four 64-bit state words that
// serves one request at a time. A reseed request refills the state with four
// splitmix64 draws from the seed (a zero seed is replaced by a fixed
// constant) and produces no result transfer. A raw request returns the next
// generator word. A uniform request returns a value in the inclusive range
// [range_low, range_high] by rejection sampling; an empty or inverted range
// returns range_low without advancing the state. A chance request returns
// hit = 1 with probability prob_num / prob_den, and hit = 0 when prob_den is
// zero. The input is stalled for the whole of a request, and a finished
// result sits in an output register so that the next request can be taken
// while it waits to be collected. A reseed makes eight passes through the
// multi-cycle 64-bit multiplier, which uses one 32 x 32 multiplier in the
// phases LL, LH, HL, SUM and OUT. Uniform and chance requests with a
// non-trivial range make two passes through the bit-serial remainder unit,
// one for the rejection threshold and one for the final reduction, and draw
// again for each rejected word. After reset the block reseeds itself with
// seed zero and holds the input stalled until that reseed is done.
`include "xoshiro_range_random_generator_unit_defines.svh"

module xoshiro_range_random_generator_unit
    import xrrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [63:0] seed,
    input  logic [63:0] range_low,
    input  logic [63:0] range_high,
    input  logic [31:0] prob_num,
    input  logic [31:0] prob_den,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] value,
    output logic        hit
);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SEED_ADV = 4'd1;
    localparam logic [3:0] ST_SEED_M1  = 4'd2;
    localparam logic [3:0] ST_SEED_W1  = 4'd3;
    localparam logic [3:0] ST_SEED_M2  = 4'd4;
    localparam logic [3:0] ST_SEED_W2  = 4'd5;
    localparam logic [3:0] ST_PREP     = 4'd6;
    localparam logic [3:0] ST_LIM_W    = 4'd7;
    localparam logic [3:0] ST_DRAW1    = 4'd8;
    localparam logic [3:0] ST_DRAW2    = 4'd9;
    localparam logic [3:0] ST_CHECK    = 4'd10;
    localparam logic [3:0] ST_REM_W    = 4'd11;
    localparam logic [3:0] ST_FINISH   = 4'd12;

    // Control state.
    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    word_t      ctr_reg;
    word_t      ctr_next;
    req_t       kind_reg;
    req_t       kind_next;
    logic       direct_reg;
    logic       direct_next;

    // Generator state and working registers.
    word_t gen_reg  [4];
    word_t gen_next [4];
    word_t lo_reg;
    word_t lo_next;
    word_t hi_reg;
    word_t hi_next;
    word_t span_reg;
    word_t span_next;
    word_t limit_reg;
    word_t limit_next;
    word_t tmp_reg;
    word_t tmp_next;
    word_t word_reg;
    word_t word_next;
    word_t res_reg;
    word_t res_next;
    half_t num_reg;
    half_t num_next;
    word_t value_reg;
    word_t value_next;
    logic  hit_reg;
    logic  hit_next;

    // Shared unit hookup.
    logic  mul_start;
    word_t mul_a;
    word_t mul_b;
    logic  mul_done;
    word_t mul_prod;
    logic  div_start;
    word_t div_dvd;
    word_t div_dsr;
    logic  div_done;
    word_t div_rem;

    // Combinational helpers.
    word_t span_calc;
    word_t five_s1;
    word_t word_calc;
    word_t upd_s2;
    word_t upd_s3;

    xrrg_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    xrrg_rem u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Width of the requested range; zero means all 2^64 values.
    assign span_calc = hi_reg - lo_reg + 64'd1;

    // Output scrambler s1 * 5 rotated by 7 and then times 9, done as shift-adds.
    assign five_s1   = gen_reg[1] + {gen_reg[1][WORD_W-3:0], 2'b00};
    assign word_calc = tmp_reg + {tmp_reg[WORD_W-4:0], 3'b000};

    // Intermediate words of the xoshiro state update.
    assign upd_s2 = gen_reg[2] ^ gen_reg[0];
    assign upd_s3 = gen_reg[3] ^ gen_reg[1];

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        ctr_next       = ctr_reg;
        kind_next      = kind_reg;
        direct_next    = direct_reg;
        gen_next       = gen_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        span_next      = span_reg;
        limit_next     = limit_reg;
        tmp_next       = tmp_reg;
        word_next      = word_reg;
        res_next       = res_reg;
        num_next       = num_reg;
        value_next     = value_reg;
        hit_next       = hit_reg;
        mul_start      = 1'b0;
        mul_a          = ctr_reg ^ (ctr_reg >> 30);
        mul_b          = MIX_MUL_A;
        div_start      = 1'b0;
        div_dvd        = word_reg;
        div_dsr        = span_reg;

        // A waiting result leaves on its transfer.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next   = req_type;
                    direct_next = 1'b0;
                    unique case (req_type)
                        REQ_RESEED:
                        begin
                            ctr_next   = (seed == '0) ? ZERO_SEED_SUB : seed;
                            idx_next   = 2'd0;
                            state_next = ST_SEED_ADV;
                        end
                        REQ_RAW:
                        begin
                            direct_next = 1'b1;
                            state_next  = ST_DRAW1;
                        end
                        REQ_UNIFORM:
                        begin
                            lo_next    = range_low;
                            hi_next    = range_high;
                            state_next = ST_PREP;
                        end
                        default:
                        begin
                            // A zero denominator becomes the empty range [0, 0]
                            // with a zero numerator, so the compare gives a miss.
                            lo_next    = '0;
                            hi_next    = (prob_den == '0) ? '0
                                       : {{HALF_W{1'b0}}, prob_den - 32'd1};
                            num_next   = (prob_den == '0) ? '0 : prob_num;
                            state_next = ST_PREP;
                        end
                    endcase
                end
            end
            ST_SEED_ADV:
            begin
                ctr_next   = ctr_reg + GOLDEN_STEP;
                state_next = ST_SEED_M1;
            end
            ST_SEED_M1:
            begin
                mul_start  = 1'b1;
                state_next = ST_SEED_W1;
            end
            ST_SEED_W1:
            begin
                if (mul_done)
                begin
                    state_next = ST_SEED_M2;
                end
            end
            ST_SEED_M2:
            begin
                mul_start  = 1'b1;
                mul_a      = mul_prod ^ (mul_prod >> 27);
                mul_b      = MIX_MUL_B;
                state_next = ST_SEED_W2;
            end
            ST_SEED_W2:
            begin
                if (mul_done)
                begin
                    gen_next[idx_reg] = mul_prod ^ (mul_prod >> 31);
                    idx_next          = idx_reg + 2'd1;
                    state_next        = (idx_reg == 2'd3) ? ST_IDLE : ST_SEED_ADV;
                end
            end
            ST_PREP:
            begin
                if (hi_reg <= lo_reg)
                begin
                    // Empty or inverted range: answer the lower bound, no draw.
                    res_next   = lo_reg;
                    state_next = ST_FINISH;
                end
                else if (span_calc == '0)
                begin
                    // The range covers every word, so a raw draw is the answer.
                    direct_next = 1'b1;
                    state_next  = ST_DRAW1;
                end
                else
                begin
                    // Rejection threshold (2^64 - span) mod span.
                    span_next  = span_calc;
                    div_start  = 1'b1;
                    div_dvd    = '0 - span_calc;
                    div_dsr    = span_calc;
                    state_next = ST_LIM_W;
                end
            end
            ST_LIM_W:
            begin
                if (div_done)
                begin
                    limit_next = div_rem;
                    state_next = ST_DRAW1;
                end
            end
            ST_DRAW1:
            begin
                tmp_next    = {five_s1[WORD_W-8:0], five_s1[WORD_W-1:WORD_W-7]};
                gen_next[0] = gen_reg[0] ^ upd_s3;
                gen_next[1] = gen_reg[1] ^ upd_s2;
                gen_next[2] = upd_s2 ^ {gen_reg[1][WORD_W-18:0], 17'd0};
                gen_next[3] = {upd_s3[WORD_W-46:0], upd_s3[WORD_W-1:WORD_W-45]};
                state_next  = ST_DRAW2;
            end
            ST_DRAW2:
            begin
                word_next = word_calc;
                if (direct_reg)
                begin
                    res_next   = word_calc;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (word_reg >= limit_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_REM_W;
                end
                else
                begin
                    state_next = ST_DRAW1;
                end
            end
            ST_REM_W:
            begin
                if (div_done)
                begin
                    res_next   = lo_reg + div_rem;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Load the output register once it is free or being emptied.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (kind_reg == REQ_CHANCE)
                    begin
                        value_next = '0;
                        hit_next   = (res_reg < {{HALF_W{1'b0}}, num_reg});
                    end
                    else
                    begin
                        value_next = res_reg;
                        hit_next   = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // After reset the sequencer starts a reseed with the zero-seed constant.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SEED_ADV;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            ctr_reg       <= ZERO_SEED_SUB;
            kind_reg      <= REQ_RESEED;
            direct_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            ctr_reg       <= ctr_next;
            kind_reg      <= kind_next;
            direct_reg    <= direct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gen_reg   <= gen_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        span_reg  <= span_next;
        limit_reg <= limit_next;
        tmp_reg   <= tmp_next;
        word_reg  <= word_next;
        res_reg   <= res_next;
        num_reg   <= num_next;
        value_reg <= value_next;
        hit_reg   <= hit_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign hit       = hit_reg;

    // The multiplier only reports completion while the sequencer waits for it.
    `XRRG_ASSERT_IMPL(a_mul_done_expected, mul_done,
        (state_reg == ST_SEED_W1) || (state_reg == ST_SEED_W2),
        "multiplier finished outside a seeding wait state")

    // The remainder unit only reports completion while the sequencer waits for it.
    `XRRG_ASSERT_IMPL(a_div_done_expected, div_done,
        (state_reg == ST_LIM_W) || (state_reg == ST_REM_W),
        "remainder unit finished outside a division wait state")

    // A finished result holds its place while the previous one is still stalled.
    `XRRG_ASSERT_NEXT(a_finish_holds,
        (state_reg == ST_FINISH) && out_valid_reg && out_stall,
        state_reg == ST_FINISH,
        "result left the sequencer while the output register was occupied")

    // The xoshiro state is never all zero once a request can be taken.
    `XRRG_ASSERT_IMPL(a_state_nonzero, state_reg == ST_IDLE,
        (gen_reg[0] | gen_reg[1] | gen_reg[2] | gen_reg[3]) != '0,
        "generator state is all zero")

endmodule

>>> dv/tb_xoshiro_range_random_generator_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the xoshiro256** range generator unit.
// Depends on xrrg_pkg and the xoshiro_range_random_generator_unit RTL only.
module tb_xoshiro_range_random_generator_unit;
    import xrrg_pkg::*;

    typedef bit [63:0] u64;

    // One expected result transfer. Raw and uniform requests carry a word
    // with hit low, and chance requests carry hit with a zero word.
    typedef struct packed {
        u64 value;
        bit hit;
    } draw_result_t;

    // The scoreboard holds its own copy of the four generator words. Each
    // accepted request advances that copy exactly as the block should, and
    // any result it causes is queued until the block hands one over.
    class draw_scoreboard;
        u64           gen_state[4];
        draw_result_t expected_draws[$];
        int           failures;

        function new();
            failures = 0;
            reseed_state(64'd0);
        endfunction

        static function u64 rotl(u64 v, int r);
            return (v << r) | (v >> (64 - r));
        endfunction

        // One splitmix64 step; the counter is carried between the four draws.
        static function u64 splitmix_next(ref u64 ctr);
            u64 z;
            ctr = ctr + GOLDEN_STEP;
            z = ctr;
            z = (z ^ (z >> 30)) * MIX_MUL_A;
            z = (z ^ (z >> 27)) * MIX_MUL_B;
            return z ^ (z >> 31);
        endfunction

        function void reseed_state(u64 sd);
            u64 ctr;
            ctr = (sd == 64'd0) ? ZERO_SEED_SUB : sd;
            for (int i = 0; i < 4; i++)
                gen_state[i] = splitmix_next(ctr);
        endfunction

        function u64 next_word();
            u64 res;
            u64 t;
            res = rotl(gen_state[1] * 64'd5, 7) * 64'd9;
            t = gen_state[1] << 17;
            gen_state[2] ^= gen_state[0];
            gen_state[3] ^= gen_state[1];
            gen_state[1] ^= gen_state[2];
            gen_state[0] ^= gen_state[3];
            gen_state[2] ^= t;
            gen_state[3] = rotl(gen_state[3], 45);
            return res;
        endfunction

        // Unbiased draw from [lo, hi] by rejecting words below (2^64 mod span).
        function u64 draw_in_range(u64 lo, u64 hi);
            u64 span;
            u64 threshold;
            u64 w;
            if (hi <= lo)
                return lo;
            span = hi - lo + 64'd1;
            if (span == 64'd0)
                return next_word();
            threshold = (64'd0 - span) % span;
            forever
            begin
                w = next_word();
                if (w >= threshold)
                    return lo + (w % span);
            end
        endfunction

        function void note_request(req_t kind, u64 sd, u64 lo, u64 hi,
                                   bit [31:0] num, bit [31:0] den);
            draw_result_t r;
            r = '0;
            case (kind)
                REQ_RESEED:
                begin
                    reseed_state(sd);
                    return;
                end
                REQ_RAW:     r.value = next_word();
                REQ_UNIFORM: r.value = draw_in_range(lo, hi);
                default:
                begin
                    if (den != 32'd0)
                        r.hit = (draw_in_range(64'd0, u64'(den) - 64'd1) < u64'(num));
                end
            endcase
            expected_draws.push_back(r);
        endfunction

        function void check_result(u64 got_value, bit got_hit);
            draw_result_t want;
            if (expected_draws.size() == 0)
            begin
                $error("unexpected result transfer: value %h hit %0d", got_value, got_hit);
                failures++;
                return;
            end
            want = expected_draws.pop_front();
            if (got_value !== want.value)
            begin
                $error("value mismatch: expected %h, actual %h", want.value, got_value);
                failures++;
            end
            if (got_hit !== want.hit)
            begin
                $error("hit mismatch: expected %0d, actual %0d", want.hit, got_hit);
                failures++;
            end
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [63:0] seed;
    logic [63:0] range_low;
    logic [63:0] range_high;
    logic [31:0] prob_num;
    logic [31:0] prob_den;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] value;
    logic        hit;

    draw_scoreboard sb = new();

    // Upper bound on the idle cycles either side inserts per transfer; set to
    // zero for stretches in which both sides run flat out.
    int idle_max = 9;

    xoshiro_range_random_generator_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .seed       (seed),
        .range_low  (range_low),
        .range_high (range_high),
        .prob_num   (prob_num),
        .prob_den   (prob_den),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .hit        (hit)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic u64 rnd64();
        return {$urandom, $urandom};
    endfunction

    // Presents one request after a random gap and holds it until the block
    // takes it. Inputs move only on the falling edge, and each falling edge
    // sees a single assignment to in_valid, so a back-to-back transfer simply
    // leaves valid high.
    task automatic send_request(req_t kind, u64 sd, u64 lo, u64 hi,
                                bit [31:0] num, bit [31:0] den);
        int gap;
        gap = $urandom_range(0, idle_max);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        req_type   <= kind;
        seed       <= sd;
        range_low  <= lo;
        range_high <= hi;
        prob_num   <= num;
        prob_den   <= den;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(kind, sd, lo, hi, num, den);
    endtask

    // The sender goes quiet until every outstanding result has been collected.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Directed requests: the default seed after reset, every request kind,
    // the empty, inverted and full ranges, a range just above 2^63 where
    // nearly half of all draws are rejected, and the zero and unit
    // denominators of the chance test. Fields a request ignores carry noise.
    task automatic run_directed();
        send_request(REQ_RAW, rnd64(), rnd64(), rnd64(), $urandom, $urandom);
        send_request(REQ_RAW, rnd64(), rnd64(), rnd64(), $urandom, $urandom);
        send_request(REQ_UNIFORM, rnd64(), 64'd5, 64'd5, $urandom, $urandom);
        send_request(REQ_UNIFORM, rnd64(), '1, 64'd0, $urandom, $urandom);
        send_request(REQ_UNIFORM, rnd64(), 64'd0, '1, $urandom, $urandom);
        send_request(REQ_UNIFORM, rnd64(), 64'd0, 64'h8000_0000_0000_0000,
                     $urandom, $urandom);
        send_request(REQ_UNIFORM, rnd64(), 64'hFFFF_FFFF_FFFF_FFFE, '1,
                     $urandom, $urandom);
        send_request(REQ_UNIFORM, rnd64(), 64'd100, 64'd109, $urandom, $urandom);
        send_request(REQ_UNIFORM, rnd64(), 64'd0, 64'hFFFF_FFFF_FFFF_FFFE,
                     $urandom, $urandom);
        send_request(REQ_CHANCE, rnd64(), rnd64(), rnd64(), '1, 32'd0);
        send_request(REQ_CHANCE, rnd64(), rnd64(), rnd64(), 32'd0, 32'd1);
        send_request(REQ_CHANCE, rnd64(), rnd64(), rnd64(), 32'd1, 32'd1);
        send_request(REQ_CHANCE, rnd64(), rnd64(), rnd64(), '1, '1);
        send_request(REQ_CHANCE, rnd64(), rnd64(), rnd64(), 32'd0, '1);
        send_request(REQ_CHANCE, rnd64(), rnd64(), rnd64(), 32'd5, 32'd3);
        send_request(REQ_CHANCE, rnd64(), rnd64(), rnd64(), 32'd1, 32'd2);
        send_request(REQ_RESEED, 64'd0, rnd64(), rnd64(), $urandom, $urandom);
        send_request(REQ_RAW, rnd64(), rnd64(), rnd64(), $urandom, $urandom);
        send_request(REQ_RESEED, '1, rnd64(), rnd64(), $urandom, $urandom);
        send_request(REQ_RAW, rnd64(), rnd64(), rnd64(), $urandom, $urandom);
        // Two reseeds in a row: only the second one should count.
        send_request(REQ_RESEED, 64'd1, rnd64(), rnd64(), $urandom, $urandom);
        send_request(REQ_RESEED, 64'h8000_0000_0000_0000, rnd64(), rnd64(),
                     $urandom, $urandom);
        send_request(REQ_UNIFORM, rnd64(), 64'd0, 64'd1, $urandom, $urandom);
        send_request(REQ_RAW, rnd64(), rnd64(), rnd64(), $urandom, $urandom);
    endtask

    // Random requests. Ranges are shaped so that small spans, spans just
    // above a power of two (heavy rejection), very wide spans, inverted
    // ranges and the full range all turn up regularly; chance requests mix
    // small and full-width denominators.
    task automatic run_random(int count);
        int        pick;
        int        shape;
        int        k;
        u64        lo;
        u64        hi;
        bit [31:0] num;
        bit [31:0] den;
        for (int i = 0; i < count; i++)
        begin
            idle_max = ((i / 125) % 3 == 2) ? 0 : 9;
            if (i == count / 2)
                drain_results();
            pick = $urandom_range(0, 99);
            lo  = rnd64();
            hi  = rnd64();
            num = $urandom;
            den = $urandom;
            if (pick < 8)
            begin
                send_request(REQ_RESEED, ($urandom_range(0, 9) == 0) ? 64'd0 : rnd64(),
                             lo, hi, num, den);
            end
            else if (pick < 35)
            begin
                send_request(REQ_RAW, rnd64(), lo, hi, num, den);
            end
            else if (pick < 70)
            begin
                shape = $urandom_range(0, 9);
                case (shape)
                    0, 1: hi = lo + u64'($urandom_range(0, 1000));
                    2, 3:
                    begin
                        k  = $urandom_range(1, 63);
                        hi = lo + (64'd1 << k) + u64'($urandom_range(0, 2)) - 64'd1;
                    end
                    4, 5:
                    begin
                        lo = u64'($urandom_range(0, 1000));
                        hi = lo + 64'h8000_0000_0000_0000 + (rnd64() >> $urandom_range(1, 63));
                    end
                    6: hi = lo - u64'($urandom_range(0, 3));
                    7:
                    begin
                        lo = 64'd0;
                        hi = '1;
                    end
                    default: ;
                endcase
                send_request(REQ_UNIFORM, rnd64(), lo, hi, num, den);
            end
            else
            begin
                shape = $urandom_range(0, 9);
                case (shape)
                    0: den = 32'd0;
                    1: den = 32'd1;
                    2, 3, 4: den = $urandom_range(2, 20);
                    default: ;
                endcase
                if ($urandom_range(0, 1) == 0)
                    num = (den == 32'd0) ? $urandom : $urandom_range(0, den);
                send_request(REQ_CHANCE, rnd64(), lo, hi, num, den);
            end
        end
    endtask

    // Receiving side: holds the stall for a random number of cycles, then
    // waits with stall low for the next transfer and checks it against the
    // oldest expectation.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = $urandom_range(0, idle_max);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(value, hit);
        end
    end

    // Main sequence. After reset the block reseeds itself and keeps the
    // input stalled, so the first request simply waits for that to finish.
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = REQ_RESEED;
        seed       = '0;
        range_low  = '0;
        range_high = '0;
        prob_num   = '0;
        prob_den   = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        drain_results();
        run_random(750);

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // A trailing reseed or a stray result would show up in this window.
        repeat (300) @(posedge clk);

        if (sb.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: many times the slowest legal run of about 2 ms.
    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/xrrg_pkg.sv
hdl/xrrg_mul.sv
hdl/xrrg_rem.sv
hdl/xoshiro_range_random_generator_unit.sv
dv/tb_xoshiro_range_random_generator_unit.sv
